>>> design/tfkp_pkg.sv
// Package for the TCP flow key header parser: constants, widths and the
// key record shared by the parser, the key queue and the output stage.
// No dependencies.
package tfkp_pkg;

   localparam int POSITION_BITS = 16;
   localparam int MAX_VLAN_TAGS = 4;
   localparam int TAG_BITS      = 3;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] ETYPE_QTAG       = 16'h8100;
   localparam logic [15:0] ETYPE_ADTAG      = 16'h88A8;
   localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
   localparam logic [15:0] VXLAN_PORT_RESET = 16'd8472;
   localparam logic [7:0]  PROTO_TCP        = 8'd6;
   localparam logic [7:0]  PROTO_UDP        = 8'd17;
   localparam int          VXLAN_SKIP_BYTES = 22;
   localparam logic [5:0]  MIN_HDR_BYTES    = 6'd20;

   // Configuration port: register index sits above the byte offset bits.
   localparam int          CSR_ADDR_BITS  = 3;
   localparam logic        REG_VXLAN_PORT = 1'b0;

   typedef struct packed {
      logic        flow_valid;
      logic [31:0] key_src_addr;
      logic [31:0] key_dst_addr;
      logic [15:0] key_src_port;
      logic [15:0] key_dst_port;
   } key_type;

endpackage

>>> design/tfkp_req_if.sv
// Byte input channel of the TCP flow key header parser.
// Stand-alone interface, no package needed.
interface tfkp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       last_byte;

   modport source (output valid, output packet_byte, output last_byte, input ready);
   modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

>>> design/tfkp_rsp_if.sv
// Flow key result channel of the TCP flow key header parser.
// Stand-alone interface, no package needed.
interface tfkp_rsp_if;
   logic        valid;
   logic        ready;
   logic        flow_valid;
   logic [31:0] key_src_addr;
   logic [31:0] key_dst_addr;
   logic [15:0] key_src_port;
   logic [15:0] key_dst_port;

   modport source (output valid, output flow_valid, output key_src_addr,
                   output key_dst_addr, output key_src_port, output key_dst_port,
                   input ready);
   modport sink (input valid, input flow_valid, input key_src_addr,
                 input key_dst_addr, input key_src_port, input key_dst_port,
                 output ready);
endinterface

>>> design/tfkp_front.sv
// Front end: byte-serial header parser that walks the Ethernet, VLAN, IPv4,
// UDP/VXLAN and TCP headers and emits one key record per packet.
// Depends on tfkp_pkg and tfkp_req_if.
module tfkp_front (
   input  logic             clock,
   input  logic             reset,
   tfkp_req_if.sink         req,
   input  logic [15:0]      vxlan_port,
   input  logic             queue_full,
   output logic             push,
   output tfkp_pkg::key_type push_key
);
   import tfkp_pkg::*;

   typedef enum logic [2:0] {
      PH_ETH, PH_VLAN, PH_IP_OUTER, PH_UDP, PH_SKIP, PH_IP_INNER, PH_TCP, PH_DONE
   } phase_type;

   localparam int PB = POSITION_BITS;

   logic [PB-1:0]       pos_ff, pos_in;
   phase_type           phase_ff, phase_in;
   logic [TAG_BITS-1:0] tags_ff, tags_in;
   logic [15:0]         etype_ff, etype_in;
   logic [PB-1:0]       hstart_ff, hstart_in;
   logic [5:0]          ihb_ff, ihb_in;
   logic [7:0]          proto_ff, proto_in;
   logic [15:0]         reqlen_ff, reqlen_in;
   logic [31:0]         src_ff, src_in;
   logic [31:0]         dst_ff, dst_in;
   logic [31:0]         ports_ff, ports_in;
   logic                rej_ff, rej_in;

   logic [PB-1:0]       off;
   logic [PB:0]         pos_inc;
   logic [PB:0]         off_inc;
   logic [PB-1:0]       hs_next;
   logic [15:0]         etype_shift;
   logic [TAG_BITS-1:0] tags_inc;
   logic                accept;

   assign accept  = req.valid && req.ready;
   assign req.ready = !queue_full;
   assign push    = accept && req.last_byte;

   assign off         = pos_ff - hstart_ff;
   assign pos_inc     = {1'b0, pos_ff} + (PB+1)'(1);
   assign off_inc     = {1'b0, off} + (PB+1)'(1);
   assign hs_next     = pos_inc[PB-1:0];
   assign etype_shift = {etype_ff[7:0], req.packet_byte};
   assign tags_inc    = tags_ff + TAG_BITS'(1);

   always_comb begin
      logic       ip_stop;
      logic [5:0] dlen;
      phase_in  = phase_ff;
      tags_in   = tags_ff;
      etype_in  = etype_ff;
      hstart_in = hstart_ff;
      ihb_in    = ihb_ff;
      proto_in  = proto_ff;
      reqlen_in = reqlen_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      ports_in  = ports_ff;
      rej_in    = rej_ff;
      ip_stop   = 1'b0;
      dlen      = 6'd0;

      if (!rej_ff) begin
         unique case (phase_ff)
            PH_ETH: begin
               if (off == PB'(12) || off == PB'(13)) begin
                  etype_in = etype_shift;
               end
               if (off == PB'(13)) begin
                  if (etype_shift == ETYPE_QTAG || etype_shift == ETYPE_ADTAG) begin
                     if (tags_ff < TAG_BITS'(MAX_VLAN_TAGS)) begin
                        phase_in  = PH_VLAN;
                        hstart_in = hs_next;
                     end else begin
                        rej_in = 1'b1;
                     end
                  end else if (etype_shift == ETYPE_IPV4) begin
                     phase_in  = PH_IP_OUTER;
                     hstart_in = hs_next;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
            end
            PH_VLAN: begin
               if (off == PB'(2) || off == PB'(3)) begin
                  etype_in = etype_shift;
               end
               if (off == PB'(3)) begin
                  tags_in = tags_inc;
                  if (etype_shift == ETYPE_QTAG || etype_shift == ETYPE_ADTAG) begin
                     if (tags_inc < TAG_BITS'(MAX_VLAN_TAGS)) begin
                        phase_in  = PH_VLAN;
                        hstart_in = hs_next;
                     end else begin
                        rej_in = 1'b1;
                     end
                  end else if (etype_shift == ETYPE_IPV4) begin
                     phase_in  = PH_IP_OUTER;
                     hstart_in = hs_next;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
            end
            PH_IP_OUTER, PH_IP_INNER: begin
               if (off == PB'(0)) begin
                  if (req.packet_byte[3:0] < 4'd5) begin
                     rej_in  = 1'b1;
                     ip_stop = 1'b1;
                  end else begin
                     ihb_in = {req.packet_byte[3:0], 2'b00};
                  end
               end else if (off == PB'(9)) begin
                  proto_in = req.packet_byte;
               end else if (off >= PB'(12) && off <= PB'(15)) begin
                  src_in = {src_ff[23:0], req.packet_byte};
               end else if (off >= PB'(16) && off <= PB'(19)) begin
                  dst_in = {dst_ff[23:0], req.packet_byte};
               end
               // The header ends on the byte whose offset plus one is IHL*4.
               if (!ip_stop && off_inc == (PB+1)'(ihb_in)) begin
                  if (proto_in == PROTO_TCP) begin
                     phase_in  = PH_TCP;
                     hstart_in = hs_next;
                     ports_in  = 32'd0;
                     reqlen_in = 16'(hs_next) + 16'(MIN_HDR_BYTES);
                  end else if (phase_ff == PH_IP_OUTER && proto_in == PROTO_UDP) begin
                     phase_in  = PH_UDP;
                     hstart_in = hs_next;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
            end
            PH_UDP: begin
               if (off == PB'(2) || off == PB'(3)) begin
                  etype_in = etype_shift;
               end
               if (off == PB'(7)) begin
                  if (etype_ff == vxlan_port) begin
                     phase_in  = PH_SKIP;
                     hstart_in = hs_next;
                  end else begin
                     rej_in = 1'b1;
                  end
               end
            end
            PH_SKIP: begin
               if (off == PB'(VXLAN_SKIP_BYTES - 1)) begin
                  phase_in  = PH_IP_INNER;
                  hstart_in = hs_next;
                  src_in    = 32'd0;
                  dst_in    = 32'd0;
                  ihb_in    = 6'd0;
                  proto_in  = 8'd0;
               end
            end
            PH_TCP: begin
               if (off <= PB'(3)) begin
                  ports_in = {ports_ff[23:0], req.packet_byte};
               end else if (off == PB'(12)) begin
                  dlen = {req.packet_byte[7:4], 2'b00};
                  if (dlen < MIN_HDR_BYTES) begin
                     dlen = MIN_HDR_BYTES;
                  end
                  reqlen_in = 16'(hstart_ff) + 16'(dlen);
               end
               if (17'(pos_inc) == {1'b0, reqlen_in}) begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE: begin
            end
         endcase
      end

      pos_in = (pos_ff == {PB{1'b1}}) ? pos_ff : pos_inc[PB-1:0];
   end

   always_comb begin
      push_key = '0;
      if (!rej_in && phase_in == PH_DONE) begin
         push_key.flow_valid   = 1'b1;
         push_key.key_src_addr = dst_in;
         push_key.key_dst_addr = src_in;
         push_key.key_src_port = ports_in[15:0];
         push_key.key_dst_port = ports_in[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff    <= '0;
         phase_ff  <= PH_ETH;
         tags_ff   <= '0;
         etype_ff  <= '0;
         hstart_ff <= '0;
         ihb_ff    <= '0;
         proto_ff  <= '0;
         reqlen_ff <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
         ports_ff  <= '0;
         rej_ff    <= 1'b0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         tags_ff   <= tags_in;
         etype_ff  <= etype_in;
         hstart_ff <= hstart_in;
         ihb_ff    <= ihb_in;
         proto_ff  <= proto_in;
         reqlen_ff <= reqlen_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         ports_ff  <= ports_in;
         rej_ff    <= rej_in;
      end
   end

endmodule

>>> design/tfkp_queue.sv
// Short key queue between the parser and the output stage.
// Depends on tfkp_pkg.
module tfkp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tfkp_pkg::key_type push_key,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output tfkp_pkg::key_type head_key
);
   import tfkp_pkg::*;

   key_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_key   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + QPTR_BITS'(1);
      end
      count_in = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_key;
      end
   end

endmodule

>>> design/tfkp_back.sv
// Back end: output register that presents one key beat on the result channel.
// Depends on tfkp_pkg and tfkp_rsp_if.
module tfkp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  tfkp_pkg::key_type head_key,
   output logic              pop,
   tfkp_rsp_if.source        rsp
);
   import tfkp_pkg::*;

   logic    valid_ff, valid_in;
   key_type key_ff;

   // The register reloads whenever it is empty or its beat is being taken.
   assign pop      = head_valid && (!valid_ff || rsp.ready);
   assign valid_in = pop || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         key_ff <= head_key;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.flow_valid   = key_ff.flow_valid;
   assign rsp.key_src_addr = key_ff.key_src_addr;
   assign rsp.key_dst_addr = key_ff.key_dst_addr;
   assign rsp.key_src_port = key_ff.key_src_port;
   assign rsp.key_dst_port = key_ff.key_dst_port;

endmodule

>>> design/tcp_flow_key_header_parser_top.sv
// Channel  | Dir | Payload                                        | Beat
// ---------+-----+------------------------------------------------+-----------------------
// req      | in  | packet_byte, last_byte                         | valid & ready
// rsp      | out | flow_valid, key_src/dst_addr, key_src/dst_port | valid & ready
// csr      | in  | APB write of vxlan_udp_port at byte address 0  | psel & penable & pwrite
//
// The parser takes one byte beat per cycle while req.ready is high, a rate set by the
// parser step; a key passes the key queue and the output register, then leaves on rsp.
// A two-entry key queue and the output register let rsp stall without stopping the
// byte stream until three keys wait; then req.ready drops. Reset is synchronous and
// clears the parse state, the queue and the output register; the port register
// returns to 8472. Depends on tfkp_pkg, the two channel interfaces and the submodules.
module tcp_flow_key_header_parser_top (
   input  logic                               clock,
   input  logic                               reset,
   tfkp_req_if.sink                           req,
   tfkp_rsp_if.source                         rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tfkp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import tfkp_pkg::*;

   logic [15:0] vxlan_port_ff, vxlan_port_in;
   logic        csr_write;
   logic        queue_full;
   logic        push;
   key_type     push_key;
   logic        pop;
   logic        head_valid;
   key_type     head_key;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      vxlan_port_in = vxlan_port_ff;
      if (csr_write && csr_paddr[CSR_ADDR_BITS-1] == REG_VXLAN_PORT) begin
         vxlan_port_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vxlan_port_ff <= VXLAN_PORT_RESET;
      end else begin
         vxlan_port_ff <= vxlan_port_in;
      end
   end

   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1] == REG_VXLAN_PORT) ?
                       {16'd0, vxlan_port_ff} : 32'd0;

   tfkp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .vxlan_port (vxlan_port_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_key   (push_key)
   );

   tfkp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_key   (push_key),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_key   (head_key)
   );

   tfkp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_key   (head_key),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule
